>>> rtl/wmlp_pkg.sv
package wmlp_pkg;

  localparam int INDEX_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int RANGE_BITS      = 32;

  localparam logic [2:0] VERSION_RESET = 3'd1;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_VERSION = 2'd1,
    ST_NAME_TRUNC  = 2'd2
  } status_t;

  // one accepted byte: an optional name or range word, then an optional end word
  typedef struct packed {
    logic                  first_vld;
    logic                  first_range;
    logic [7:0]            name_char;
    logic [RANGE_BITS-1:0] range_start;
    logic [RANGE_BITS-1:0] range_extra;
    logic                  end_vld;
    status_t               end_status;
  } cmd_t;

endpackage

>>> rtl/wallet_metadata_leb128_parser_unit.sv
// Metadata record parser: takes one record byte per cycle and returns name
// bytes, wallet index ranges from unsigned LEB128 start/count pairs, and an
// end status word on the final byte. A byte is taken in the cycle it is
// pushed whenever the command queue between parser and output stage has room,
// so bytes that cause at most one word stream at one per cycle; a byte that
// causes two words (a final byte that is a name byte or closes a range) holds
// the output stage for two pops. Words reach the result ports from the
// command queue, which drives them directly. QUEUE_DEPTH sets how many bytes'
// worth of words can wait while pop is low before full rises.
module wallet_metadata_leb128_parser_unit #(
  parameter int INDEX_BITS  = wmlp_pkg::INDEX_BITS_DEF,
  parameter int QUEUE_DEPTH = wmlp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_final_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_name_char,
  output logic [wmlp_pkg::RANGE_BITS-1:0] out_range_start,
  output logic [wmlp_pkg::RANGE_BITS-1:0] out_range_extra,
  output logic [1:0]                      out_end_status,
  output logic                            out_run_end
);
  import wmlp_pkg::*;

  logic q_full;
  logic q_wr;
  cmd_t q_wdata;
  logic q_rd;
  cmd_t q_rd_data;
  logic q_empty;

  wmlp_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .in_final_byte(in_final_byte),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wdata      (q_wdata)
  );

  wmlp_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_data(q_wdata),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  wmlp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rd_data      (q_rd_data),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_name_char  (out_name_char),
    .out_range_start(out_range_start),
    .out_range_extra(out_range_extra),
    .out_end_status (out_end_status),
    .out_run_end    (out_run_end)
  );

  a_full_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full while no word waits");

  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_END) |-> out_run_end)
    else $error("end status word without run end");

  a_final_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_final_byte) |=> !out_empty)
    else $error("final byte left no word");

  a_run_end_on_end_only_or_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_run_end) |-> (out_kind == KIND_NAME || out_kind == KIND_RANGE))
    else $error("open run on an end status word");

endmodule

>>> rtl/wmlp_front.sv
module wmlp_front #(
  parameter int INDEX_BITS = wmlp_pkg::INDEX_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_wdata,
  input  logic            in_push,
  output logic            in_full,
  input  logic [7:0]      in_data_byte,
  input  logic            in_final_byte,
  input  logic            q_full,
  output logic            q_wr,
  output wmlp_pkg::cmd_t  q_wdata
);
  import wmlp_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_NAME    = 5'b00010,
    PH_START   = 5'b00100,
    PH_COUNT   = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [4:0]            nrem_r, nrem_nxt;
  logic [5:0]            shift_r, shift_nxt;
  logic [INDEX_BITS-1:0] start_r, start_nxt;
  logic [INDEX_BITS-1:0] count_r, count_nxt;
  logic                  err_r, err_nxt;
  logic [2:0]            ver_r;

  logic                  accept;
  logic [8:0]            pos;
  logic [INDEX_BITS-1:0] grp;
  logic [INDEX_BITS-1:0] taken_start;
  logic [INDEX_BITS-1:0] taken_count;
  logic [5:0]            shift_inc;
  logic                  trunc;
  cmd_t                  cmd;

  assign accept  = in_push & ~q_full;
  assign in_full = q_full;

  assign pos         = {shift_r, 3'b000} - {3'b000, shift_r};
  assign grp         = INDEX_BITS'(in_data_byte[6:0]);
  assign taken_start = start_r | (grp << pos);
  assign taken_count = count_r | (grp << pos);
  assign shift_inc   = (shift_r == 6'd63) ? shift_r : shift_r + 6'd1;

  always_comb begin
    phase_nxt = phase_r;
    nrem_nxt  = nrem_r;
    shift_nxt = shift_r;
    start_nxt = start_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    trunc     = 1'b0;
    cmd       = '0;
    case (phase_r)
      PH_HEADER: begin
        if (in_data_byte[7:5] != ver_r) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DISCARD;
        end else begin
          nrem_nxt  = in_data_byte[4:0];
          phase_nxt = (in_data_byte[4:0] != 5'd0) ? PH_NAME : PH_START;
          shift_nxt = 6'd0;
          trunc     = in_final_byte && (in_data_byte[4:0] != 5'd0);
        end
      end
      PH_NAME: begin
        cmd.first_vld = 1'b1;
        cmd.name_char = in_data_byte;
        nrem_nxt      = nrem_r - 5'd1;
        if (nrem_r == 5'd1) begin
          phase_nxt = PH_START;
          shift_nxt = 6'd0;
        end else if (in_final_byte) begin
          trunc = 1'b1;
        end
      end
      PH_START: begin
        start_nxt = taken_start;
        shift_nxt = shift_inc;
        if (!in_data_byte[7]) begin
          phase_nxt = PH_COUNT;
          shift_nxt = 6'd0;
        end
      end
      PH_COUNT: begin
        count_nxt = taken_count;
        shift_nxt = shift_inc;
        if (!in_data_byte[7] || in_final_byte) begin
          cmd.first_vld   = 1'b1;
          cmd.first_range = 1'b1;
          cmd.range_start = RANGE_BITS'(start_r);
          cmd.range_extra = RANGE_BITS'(taken_count);
          start_nxt       = '0;
          count_nxt       = '0;
          shift_nxt       = 6'd0;
          phase_nxt       = PH_START;
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
    if (in_final_byte) begin
      cmd.end_vld    = 1'b1;
      cmd.end_status = err_nxt ? ST_BAD_VERSION : (trunc ? ST_NAME_TRUNC : ST_OK);
      phase_nxt      = PH_HEADER;
      nrem_nxt       = 5'd0;
      shift_nxt      = 6'd0;
      start_nxt      = '0;
      count_nxt      = '0;
      err_nxt        = 1'b0;
    end
  end

  assign q_wr    = accept & (cmd.first_vld | cmd.end_vld);
  assign q_wdata = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      nrem_r  <= 5'd0;
      shift_r <= 6'd0;
      start_r <= '0;
      count_r <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      nrem_r  <= nrem_nxt;
      shift_r <= shift_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r <= VERSION_RESET;
    end else if (cfg_we) begin
      ver_r <= cfg_wdata;
    end
  end

endmodule

>>> rtl/wmlp_cmd_queue.sv
module wmlp_cmd_queue #(
  parameter int DEPTH = wmlp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  wmlp_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output wmlp_pkg::cmd_t rd_data,
  output logic           empty
);
  import wmlp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/wmlp_back.sv
module wmlp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wmlp_pkg::cmd_t                  q_rd_data,
  input  logic                            q_empty,
  output logic                            q_rd,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_name_char,
  output logic [wmlp_pkg::RANGE_BITS-1:0] out_range_start,
  output logic [wmlp_pkg::RANGE_BITS-1:0] out_range_extra,
  output logic [1:0]                      out_end_status,
  output logic                            out_run_end
);
  import wmlp_pkg::*;

  logic sub_r, sub_nxt;
  logic emit_first;
  logic pop_ok;

  assign out_empty  = q_empty;
  assign emit_first = q_rd_data.first_vld & ~sub_r;
  assign pop_ok     = out_pop & ~q_empty;
  assign q_rd       = pop_ok & ~(emit_first & q_rd_data.end_vld);

  always_comb begin
    out_kind        = KIND_END;
    out_name_char   = 8'd0;
    out_range_start = '0;
    out_range_extra = '0;
    out_end_status  = q_rd_data.end_status;
    out_run_end     = 1'b1;
    if (emit_first) begin
      out_end_status = ST_OK;
      out_run_end    = ~q_rd_data.end_vld;
      if (q_rd_data.first_range) begin
        out_kind        = KIND_RANGE;
        out_range_start = q_rd_data.range_start;
        out_range_extra = q_rd_data.range_extra;
      end else begin
        out_kind      = KIND_NAME;
        out_name_char = q_rd_data.name_char;
      end
    end
  end

  // second word of a two-word entry still pending
  always_comb begin
    sub_nxt = sub_r;
    if (pop_ok) begin
      sub_nxt = emit_first & q_rd_data.end_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

>>> test/tb_wallet_metadata_leb128_parser_unit.sv
`timescale 1ns / 100ps

module tb_wallet_metadata_leb128_parser_unit;
  import wmlp_pkg::*;

  localparam int IDX_BITS = INDEX_BITS_DEF;
  localparam int PHASE_ITEMS = 260;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam logic [8:0] FIN = 9'h100;

  localparam logic [8:0] DIRECTED [24] = '{
    FIN | 9'h020,
    FIN | 9'h023,
    FIN | 9'h0e0,
    9'h040, 9'h0ff, FIN | 9'h000,
    9'h022, 9'h000, 9'h0ff, 9'h07f, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, FIN | 9'h00f,
    9'h023, 9'h041, FIN | 9'h042,
    9'h020, 9'h085, FIN | 9'h001,
    9'h020, 9'h005, FIN | 9'h080
  };

  typedef enum logic [2:0] {
    P_HEADER,
    P_NAME,
    P_START,
    P_COUNT,
    P_DISCARD
  } parse_phase_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   name_char;
    logic [31:0]  range_start;
    logic [31:0]  range_extra;
    status_t      end_status;
    logic         run_end;
  } word_t;

  class meta_scoreboard;
    word_t        expected_words[$];
    int           errors;
    logic [2:0]   version;
    parse_phase_t phase;
    logic [4:0]   name_left;
    logic [5:0]   groups;
    logic [31:0]  start_acc;
    logic [31:0]  count_acc;
    logic         bad_version;

    function new();
      errors = 0;
      version = VERSION_RESET;
      clear_record();
    endfunction

    function void clear_record();
      phase = P_HEADER;
      name_left = '0;
      groups = '0;
      start_acc = '0;
      count_acc = '0;
      bad_version = 1'b0;
    endfunction

    function void set_version(logic [2:0] v);
      version = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic [31:0] merge_group(logic [31:0] acc, logic [7:0] b);
      logic [63:0] wide;
      int          pos;
      pos = int'(groups) * 7;
      wide = {32'b0, acc};
      if (pos < IDX_BITS) wide = wide | ({57'b0, b[6:0]} << pos);
      if (groups < 6'd63) groups = groups + 6'd1;
      return wide[31:0];
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      word_t w;
      word_t out_words[$];
      logic  truncated;
      truncated = 1'b0;
      case (phase)
        P_HEADER: begin
          if (b[7:5] != version) begin
            bad_version = 1'b1;
            phase = P_DISCARD;
          end else begin
            name_left = b[4:0];
            phase = (name_left != 0) ? P_NAME : P_START;
            groups = '0;
            if (fin && name_left != 0) truncated = 1'b1;
          end
        end
        P_NAME: begin
          w = '{kind: KIND_NAME, name_char: b, end_status: ST_OK, default: '0};
          out_words.push_back(w);
          name_left = name_left - 5'd1;
          if (name_left == 0) begin
            phase = P_START;
            groups = '0;
          end else if (fin) begin
            truncated = 1'b1;
          end
        end
        P_START: begin
          start_acc = merge_group(start_acc, b);
          if (!b[7]) begin
            phase = P_COUNT;
            groups = '0;
          end
        end
        P_COUNT: begin
          count_acc = merge_group(count_acc, b);
          if (!b[7] || fin) begin
            w = '{kind: KIND_RANGE, range_start: start_acc, range_extra: count_acc,
                  end_status: ST_OK, default: '0};
            out_words.push_back(w);
            start_acc = '0;
            count_acc = '0;
            groups = '0;
            phase = P_START;
          end
        end
        default: ;
      endcase
      if (fin) begin
        w = '{kind: KIND_END, end_status: ST_OK, default: '0};
        w.end_status = bad_version ? ST_BAD_VERSION : (truncated ? ST_NAME_TRUNC : ST_OK);
        out_words.push_back(w);
        clear_record();
      end
      if (out_words.size() > 0) out_words[out_words.size() - 1].run_end = 1'b1;
      foreach (out_words[i]) expected_words.push_back(out_words[i]);
    endfunction

    function void check_word(word_t got);
      word_t exp;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d", $time, got.kind);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      if (got.kind != exp.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
        errors++;
      end
      if (got.name_char != exp.name_char) begin
        $display("%0t: name_char expected %h actual %h", $time, exp.name_char, got.name_char);
        errors++;
      end
      if (got.range_start != exp.range_start) begin
        $display("%0t: range_start expected %h actual %h", $time, exp.range_start,
                 got.range_start);
        errors++;
      end
      if (got.range_extra != exp.range_extra) begin
        $display("%0t: range_extra expected %h actual %h", $time, exp.range_extra,
                 got.range_extra);
        errors++;
      end
      if (got.end_status != exp.end_status) begin
        $display("%0t: end_status expected %0d actual %0d", $time, exp.end_status,
                 got.end_status);
        errors++;
      end
      if (got.run_end != exp.run_end) begin
        $display("%0t: run_end expected %0d actual %0d", $time, exp.run_end, got.run_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = '0;
  logic        in_final_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_name_char;
  logic [31:0] out_range_start;
  logic [31:0] out_range_extra;
  logic [1:0]  out_end_status;
  logic        out_run_end;

  meta_scoreboard sb;
  int          send_gap_pct;
  int          pop_gap_pct;
  logic        hold_req = 1'b0;
  logic [2:0]  cur_version = VERSION_RESET;
  logic [8:0]  record_bytes[$];
  int          sent;

  wallet_metadata_leb128_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_name_char   (out_name_char),
    .out_range_start (out_range_start),
    .out_range_extra (out_range_extra),
    .out_end_status  (out_end_status),
    .out_run_end     (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random pops, long hold-off on request
  initial begin
    int    hold_left;
    word_t got;
    hold_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.kind = kind_t'(out_kind);
        got.name_char = out_name_char;
        got.range_start = out_range_start;
        got.range_extra = out_range_extra;
        got.end_status = status_t'(out_end_status);
        got.run_end = out_run_end;
        sb.check_word(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_gap_pct);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (in_full);
    sb.note_byte(b, fin);
    sent++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(input logic [2:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_version(v);
    cur_version = v;
  endtask

  task automatic add_leb();
    int r;
    int groups;
    r = $urandom_range(99);
    if (r < 2) groups = $urandom_range(64, 70);
    else if (r < 15) groups = $urandom_range(6, 10);
    else groups = $urandom_range(1, 5);
    for (int g = 0; g < groups; g++) begin
      record_bytes.push_back({1'b0, g != groups - 1, 7'($urandom)});
    end
  endtask

  task automatic send_record();
    int shape;
    int name_len;
    int cut;
    shape = $urandom_range(99);
    record_bytes.delete();
    if (shape < 75) begin
      name_len = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4);
      record_bytes.push_back({1'b0, cur_version, 5'(name_len)});
      repeat (name_len) record_bytes.push_back({1'b0, 8'($urandom)});
      repeat ($urandom_range(3)) begin
        add_leb();
        add_leb();
      end
      if ($urandom_range(3) == 0) begin
        cut = $urandom_range(record_bytes.size() - 1);
        while (record_bytes.size() > cut + 1) void'(record_bytes.pop_back());
      end
    end else if (shape < 85) begin
      record_bytes.push_back({1'b0, cur_version + 3'($urandom_range(1, 7)), 5'($urandom)});
      repeat ($urandom_range(6)) record_bytes.push_back({1'b0, 8'($urandom)});
    end else begin
      repeat ($urandom_range(1, 8)) record_bytes.push_back({1'b0, 8'($urandom)});
    end
    record_bytes[record_bytes.size() - 1][8] = 1'b1;
    foreach (record_bytes[i]) send_byte(record_bytes[i][7:0], record_bytes[i][8]);
  endtask

  initial begin
    int goal;
    sb = new();
    sent = 0;
    send_gap_pct = 10;
    pop_gap_pct = 47;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

    write_version(3'd0);
    goal = sent + PHASE_ITEMS;
    while (sent < goal) send_record();

    write_version(3'd7);
    send_gap_pct = 47;
    pop_gap_pct = 10;
    goal = sent + PHASE_ITEMS;
    while (sent < goal) send_record();

    write_version(3'($urandom_range(1, 6)));
    send_gap_pct = 0;
    pop_gap_pct = 0;
    hold_req = 1'b1;
    goal = sent + PHASE_ITEMS / 2;
    while (sent < goal) send_record();
    // sender pauses until every word is back
    drain();
    goal = sent + PHASE_ITEMS / 2;
    while (sent < goal) send_record();

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d words never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
